### hdl/srbc_pkg.sv
package srbc_pkg;

    // coordinate format
    localparam int C_FRAC_BITS = 8;
    localparam int C_CW        = 24;
    localparam int C_SZW       = 13;

    // derived working widths
    localparam int C_WB = C_SZW + C_FRAC_BITS;
    localparam int C_LW = ((C_WB > C_CW) ? C_WB : C_CW) + 3;
    localparam int C_PW = 2 * C_LW + 2;
    localparam int C_NW = 2 * C_LW;
    localparam int C_DW = C_CW + 2;
    localparam int C_QB = ((C_WB > C_CW - 1) ? C_WB : C_CW - 1) + 1;

    // configuration registers
    localparam int                 C_CFG_IW     = 1;
    localparam logic [C_CFG_IW-1:0] C_REG_WIDTH  = 1'b0;
    localparam logic [C_CFG_IW-1:0] C_REG_HEIGHT = 1'b1;
    localparam logic [C_SZW-1:0]   C_WIDTH_RST  = C_SZW'(640);
    localparam logic [C_SZW-1:0]   C_HEIGHT_RST = C_SZW'(480);

    // rectangle edges
    localparam logic [1:0] C_EDGE_TOP    = 2'd0;
    localparam logic [1:0] C_EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] C_EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] C_EDGE_LEFT   = 2'd3;

    typedef logic signed [C_CW-1:0] t_crd;
    typedef logic signed [C_LW-1:0] t_lin;
    typedef logic [C_LW-2:0]        t_mag;
    typedef logic signed [C_PW-1:0] t_prod;
    typedef logic [2*C_LW-3:0]      t_sq;
    typedef logic [2*C_LW-2:0]      t_dist;

    typedef struct packed {
        t_crd start_x;
        t_crd start_y;
        t_crd end_x;
        t_crd end_y;
    } t_seg;

    typedef struct packed {
        t_lin x1;
        t_lin y1;
        t_lin x2;
        t_lin y2;
        t_lin dx;
        t_lin dy;
    } t_geo;

    typedef struct packed {
        logic [3:0]  ok;
        t_dist [3:0] sqd;
        t_geo        geo;
    } t_test;

    typedef struct packed {
        logic       hit;
        logic [1:0] edge_idx;
        logic       vert;
        logic       startfix;
        logic       neg;
        t_crd       base;
        t_crd       fixed;
        t_crd       alt;
    } t_side;

    typedef struct packed {
        logic [C_DW-1:0] rem;
        logic [C_QB-1:0] low;
        logic [C_DW-1:0] dsr;
        t_side           side;
    } t_div_in;

    // pixel count to far edge coordinate, zero size taken as one
    function automatic t_lin size_to_lin(logic [C_SZW-1:0] sz);
        logic [C_SZW-1:0] m1;
        logic [C_WB-1:0]  fx;
        m1 = (sz == '0) ? '0 : sz - 1'b1;
        fx = C_WB'(m1) << C_FRAC_BITS;
        return t_lin'(fx);
    endfunction

    function automatic t_lin clamp_lin(t_lin v, t_lin hi);
        return (v < 0) ? t_lin'(0) : ((v > hi) ? hi : v);
    endfunction

    function automatic t_mag mag(t_lin v);
        t_lin a;
        a = (v < 0) ? -v : v;
        return a[C_LW-2:0];
    endfunction

    function automatic t_prod smul(t_lin a, t_lin b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    function automatic t_sq sqr(t_mag m);
        return t_sq'(m) * t_sq'(m);
    endfunction

endpackage

### hdl/srbc_in_if.sv
interface srbc_in_if;
    import srbc_pkg::*;
    logic valid;
    logic ready;
    t_crd start_x;
    t_crd start_y;
    t_crd end_x;
    t_crd end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

### hdl/srbc_out_if.sv
interface srbc_out_if;
    import srbc_pkg::*;
    logic       valid;
    logic       ready;
    t_crd       clip_x;
    t_crd       clip_y;
    logic       hit;
    logic [1:0] edge_index;

    modport source (output valid, output clip_x, output clip_y, output hit,
                    output edge_index, input ready);
    modport sink   (input valid, input clip_x, input clip_y, input hit,
                    input edge_index, output ready);
endinterface

### hdl/srbc_edge_test.sv
module srbc_edge_test (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  srbc_pkg::t_seg  i_seg,
    input  srbc_pkg::t_lin  i_w,
    input  srbc_pkg::t_lin  i_h,
    output logic            o_valid,
    output srbc_pkg::t_test o_test
);
    import srbc_pkg::*;

    // both line parameters within [0,1], either sign of the denominator
    function automatic logic crossing_ok(t_prod den, t_prod na, t_prod nb);
        logic pos;
        logic neg;
        pos = (den > 0) && (na >= 0) && (na <= den) && (nb >= 0) && (nb <= den);
        neg = (den < 0) && (na <= 0) && (na >= den) && (nb <= 0) && (nb >= den);
        return pos || neg;
    endfunction

    logic [4:0] r_v;

    t_lin r1_x1, r1_y1, r1_x2, r1_y2;

    t_geo r2_geo;
    t_mag r2_a0, r2_a1, r2_a3, r2_b0, r2_b1, r2_b2;

    t_geo  r3_geo;
    t_prod r3_dxy1, r3_dyx1, r3_wdy, r3_hdx, r3_wy1, r3_hx1, r3_wh;
    t_sq   r3_a0, r3_a1, r3_a3, r3_b0, r3_b1, r3_b2;

    t_geo  r4_geo;
    t_prod r4_den [4];
    t_prod r4_na  [4];
    t_prod r4_nb  [4];
    t_dist r4_d   [4];

    t_test r5_test;

    t_prod n_cross;

    assign n_cross = r3_dxy1 - r3_dyx1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // clamp start into the rectangle
            r1_x1 <= clamp_lin(t_lin'(i_seg.start_x), i_w);
            r1_y1 <= clamp_lin(t_lin'(i_seg.start_y), i_h);
            r1_x2 <= t_lin'(i_seg.end_x);
            r1_y2 <= t_lin'(i_seg.end_y);

            // deltas and midpoint offsets (doubled)
            r2_geo.x1 <= r1_x1;
            r2_geo.y1 <= r1_y1;
            r2_geo.x2 <= r1_x2;
            r2_geo.y2 <= r1_y2;
            r2_geo.dx <= r1_x2 - r1_x1;
            r2_geo.dy <= r1_y2 - r1_y1;
            r2_a0     <= mag(i_w - (r1_x2 + r1_x2));
            r2_a1     <= mag((i_w + i_w) - (r1_x2 + r1_x2));
            r2_a3     <= mag(r1_x2 + r1_x2);
            r2_b0     <= mag(r1_y2 + r1_y2);
            r2_b1     <= mag(i_h - (r1_y2 + r1_y2));
            r2_b2     <= mag((i_h + i_h) - (r1_y2 + r1_y2));

            // products
            r3_geo  <= r2_geo;
            r3_dxy1 <= smul(r2_geo.dx, r2_geo.y1);
            r3_dyx1 <= smul(r2_geo.dy, r2_geo.x1);
            r3_wdy  <= smul(i_w, r2_geo.dy);
            r3_hdx  <= smul(i_h, r2_geo.dx);
            r3_wy1  <= smul(i_w, r2_geo.y1);
            r3_hx1  <= smul(i_h, r2_geo.x1);
            r3_wh   <= smul(i_w, i_h);
            r3_a0   <= sqr(r2_a0);
            r3_a1   <= sqr(r2_a1);
            r3_a3   <= sqr(r2_a3);
            r3_b0   <= sqr(r2_b0);
            r3_b1   <= sqr(r2_b1);
            r3_b2   <= sqr(r2_b2);

            // numerators and denominators per edge
            r4_geo    <= r3_geo;
            r4_den[0] <= -r3_wdy;
            r4_na[0]  <= r3_wy1;
            r4_nb[0]  <= n_cross;
            r4_den[1] <= r3_hdx;
            r4_na[1]  <= r3_wh - r3_hx1;
            r4_nb[1]  <= n_cross + r3_wdy;
            r4_den[2] <= r3_wdy;
            r4_na[2]  <= r3_wh - r3_wy1;
            r4_nb[2]  <= n_cross - r3_hdx + r3_wdy;
            r4_den[3] <= -r3_hdx;
            r4_na[3]  <= r3_hx1;
            r4_nb[3]  <= n_cross - r3_hdx;
            r4_d[0]   <= t_dist'(r3_a0) + t_dist'(r3_b0);
            r4_d[1]   <= t_dist'(r3_a1) + t_dist'(r3_b1);
            r4_d[2]   <= t_dist'(r3_a0) + t_dist'(r3_b2);
            r4_d[3]   <= t_dist'(r3_a3) + t_dist'(r3_b1);

            // range tests
            r5_test.geo <= r4_geo;
            for (int i = 0; i < 4; i++) begin
                r5_test.ok[i]  <= crossing_ok(r4_den[i], r4_na[i], r4_nb[i]);
                r5_test.sqd[i] <= r4_d[i];
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_test  = r5_test;

endmodule

### hdl/srbc_pick.sv
module srbc_pick (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  srbc_pkg::t_test   i_test,
    input  srbc_pkg::t_lin    i_w,
    input  srbc_pkg::t_lin    i_h,
    output logic              o_valid,
    output srbc_pkg::t_div_in o_div
);
    import srbc_pkg::*;

    logic [5:0] r_v;

    t_geo       r6_geo;
    logic       r6_v01, r6_v23;
    logic [1:0] r6_i01, r6_i23;
    t_dist      r6_d01, r6_d23;

    t_geo       r7_geo;
    logic       r7_hit;
    logic [1:0] r7_edge;

    t_lin  r8_diff, r8_mulb, r8_div;
    t_side r8_side;

    t_prod r9_prod;
    t_lin  r9_div;
    t_side r9_side;

    logic [C_NW-1:0] r10_un;
    logic [C_CW:0]   r10_ud;
    t_side           r10_side;

    t_div_in r11_div;

    logic [C_NW-1:0]      n_num;
    logic [C_NW-C_QB-1:0] n_hi;
    t_lin                 n_line;
    t_side                n_side;
    t_side                n_side_sgn;
    t_lin                 n_diff, n_mulb, n_div;
    t_prod                n_pabs;
    t_lin                 n_dabs;

    // edge setup: line coordinate of the chosen edge and divide operands
    always_comb begin
        n_side          = '0;
        n_side.hit      = r7_hit;
        n_side.edge_idx = r7_edge;
        n_diff          = '0;
        n_mulb          = '0;
        n_div           = '0;
        n_line          = '0;
        if (!r7_hit) begin
            n_side.base  = r7_geo.x1[C_CW-1:0];
            n_side.fixed = r7_geo.y1[C_CW-1:0];
        end else if (r7_edge[0]) begin
            n_line          = (r7_edge == C_EDGE_RIGHT) ? i_w : t_lin'(0);
            n_side.vert     = 1'b1;
            n_side.base     = r7_geo.y1[C_CW-1:0];
            n_side.fixed    = n_line[C_CW-1:0];
            n_side.startfix = (r7_geo.x1 == n_line);
            n_side.alt      = C_CW'(clamp_lin(r7_geo.y2, i_h));
            n_diff          = n_line - r7_geo.x1;
            n_mulb          = r7_geo.dy;
            n_div           = r7_geo.dx;
        end else begin
            n_line          = (r7_edge == C_EDGE_BOTTOM) ? i_h : t_lin'(0);
            n_side.base     = r7_geo.x1[C_CW-1:0];
            n_side.fixed    = n_line[C_CW-1:0];
            n_side.startfix = (r7_geo.y1 == n_line);
            n_side.alt      = C_CW'(clamp_lin(r7_geo.x2, i_w));
            n_diff          = n_line - r7_geo.y1;
            n_mulb          = r7_geo.dx;
            n_div           = r7_geo.dy;
        end
    end

    // quotient sign rides along with the side data
    always_comb begin
        n_side_sgn     = r9_side;
        n_side_sgn.neg = (r9_prod < 0) != (r9_div < 0);
    end

    assign n_pabs = (r9_prod < 0) ? -r9_prod : r9_prod;
    assign n_dabs = (r9_div < 0) ? -r9_div : r9_div;
    assign n_num  = {r10_un[C_NW-2:0], 1'b0} + C_NW'(r10_ud);
    assign n_hi   = n_num[C_NW-1:C_QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // pairwise nearest, lower index wins ties
            r6_geo <= i_test.geo;
            r6_v01 <= i_test.ok[0] | i_test.ok[1];
            r6_v23 <= i_test.ok[2] | i_test.ok[3];
            if (i_test.ok[0] && (!i_test.ok[1] || i_test.sqd[0] <= i_test.sqd[1])) begin
                r6_i01 <= C_EDGE_TOP;
                r6_d01 <= i_test.sqd[0];
            end else begin
                r6_i01 <= C_EDGE_RIGHT;
                r6_d01 <= i_test.sqd[1];
            end
            if (i_test.ok[2] && (!i_test.ok[3] || i_test.sqd[2] <= i_test.sqd[3])) begin
                r6_i23 <= C_EDGE_BOTTOM;
                r6_d23 <= i_test.sqd[2];
            end else begin
                r6_i23 <= C_EDGE_LEFT;
                r6_d23 <= i_test.sqd[3];
            end

            r7_geo <= r6_geo;
            r7_hit <= r6_v01 | r6_v23;
            if (r6_v01 && (!r6_v23 || r6_d01 <= r6_d23)) begin
                r7_edge <= r6_i01;
            end else if (r6_v23) begin
                r7_edge <= r6_i23;
            end else begin
                r7_edge <= C_EDGE_TOP;
            end

            r8_diff <= n_diff;
            r8_mulb <= n_mulb;
            r8_div  <= n_div;
            r8_side <= n_side;

            r9_prod <= smul(r8_diff, r8_mulb);
            r9_div  <= r8_div;
            r9_side <= r8_side;

            r10_un   <= n_pabs[C_NW-1:0];
            r10_ud   <= n_dabs[C_CW:0];
            r10_side <= n_side_sgn;

            // rounding folded in: (2n + d) / 2d
            r11_div.rem  <= n_hi[C_DW-1:0];
            r11_div.low  <= n_num[C_QB-1:0];
            r11_div.dsr  <= {r10_ud, 1'b0};
            r11_div.side <= r10_side;
        end
    end

    assign o_valid = r_v[5];
    assign o_div   = r11_div;

endmodule

### hdl/srbc_div.sv
module srbc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  srbc_pkg::t_div_in     i_div,
    output logic                  o_valid,
    output logic [srbc_pkg::C_QB-1:0] o_q,
    output srbc_pkg::t_side       o_side
);
    import srbc_pkg::*;

    logic [C_QB-1:0] r_v;
    logic [C_DW-1:0] r_rem  [C_QB];
    logic [C_QB-1:0] r_low  [C_QB];
    logic [C_QB-1:0] r_q    [C_QB];
    logic [C_DW-1:0] r_dsr  [C_QB];
    t_side           r_side [C_QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[C_QB-2:0], i_valid};
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < C_QB; k++) begin : g_st
        logic [C_DW-1:0] rem_in;
        logic [C_QB-1:0] low_in;
        logic [C_QB-1:0] q_in;
        logic [C_DW-1:0] dsr_in;
        t_side           side_in;
        logic [C_DW:0]   trial;
        logic [C_DW:0]   diff;
        logic            take;

        if (k == 0) begin : g_first
            assign rem_in  = i_div.rem;
            assign low_in  = i_div.low;
            assign q_in    = '0;
            assign dsr_in  = i_div.dsr;
            assign side_in = i_div.side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign q_in    = r_q[k-1];
            assign dsr_in  = r_dsr[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = {rem_in, low_in[C_QB-1]};
        assign diff  = trial - {1'b0, dsr_in};
        assign take  = (trial >= {1'b0, dsr_in});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= take ? diff[C_DW-1:0] : trial[C_DW-1:0];
                r_low[k]  <= {low_in[C_QB-2:0], 1'b0};
                r_q[k]    <= {q_in[C_QB-2:0], take};
                r_dsr[k]  <= dsr_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[C_QB-1];
    assign o_q     = r_q[C_QB-1];
    assign o_side  = r_side[C_QB-1];

endmodule

### hdl/segment_rect_boundary_clip.sv
// each beat passes the edge test, the nearest-edge pick, the restoring divider and the output register in turn
// throughput: one beat per cycle while the output is not held; the pipelined restoring divider takes one bit a stage
// stalls freeze the whole pipeline in place when the output beat waits
// reset (synchronous, active low) clears all valid bits and loads 640 x 480
module segment_rect_boundary_clip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [srbc_pkg::C_CFG_IW-1:0] i_cfg_idx,
    input  logic [srbc_pkg::C_SZW-1:0]    i_cfg_data,
    srbc_in_if.sink                       i_seg,
    srbc_out_if.source                    o_clip
);
    import srbc_pkg::*;

    // image size registers
    logic [C_SZW-1:0] r_width;
    logic [C_SZW-1:0] r_height;

    // far edge coordinates, fixed point
    t_lin w_lin;
    t_lin h_lin;

    // whole pipeline moves together unless the output beat is held
    logic adv;

    t_seg    seg;
    logic    et_valid;
    t_test   et_test;
    logic    pk_valid;
    t_div_in pk_div;
    logic            dv_valid;
    logic [C_QB-1:0] dv_q;
    t_side           dv_side;

    // result formation
    logic signed [C_QB:0] q_s;
    t_crd                 along;
    t_crd                 n_x;
    t_crd                 n_y;

    // output register
    logic       r_out_valid;
    t_crd       r_out_x;
    t_crd       r_out_y;
    logic       r_out_hit;
    logic [1:0] r_out_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= C_WIDTH_RST;
            r_height <= C_HEIGHT_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                C_REG_WIDTH:  r_width  <= i_cfg_data;
                C_REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a size of zero behaves as one pixel
    assign w_lin = size_to_lin(r_width);
    assign h_lin = size_to_lin(r_height);

    assign adv         = !r_out_valid || o_clip.ready;
    assign i_seg.ready = adv;

    assign seg.start_x = i_seg.start_x;
    assign seg.start_y = i_seg.start_y;
    assign seg.end_x   = i_seg.end_x;
    assign seg.end_y   = i_seg.end_y;

    // stages 1-5: clamp, deltas, products, per-edge terms and distances, crossing test
    srbc_edge_test u_edge_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_seg.valid),
        .i_seg   (seg),
        .i_w     (w_lin),
        .i_h     (h_lin),
        .o_valid (et_valid),
        .o_test  (et_test)
    );

    // stages 6-11: nearest edge, divide operand setup
    srbc_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (et_valid),
        .i_test  (et_test),
        .i_w     (w_lin),
        .i_h     (h_lin),
        .o_valid (pk_valid),
        .o_div   (pk_div)
    );

    // C_QB stages: rounded quotient magnitude of the crossing offset
    srbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (pk_valid),
        .i_div   (pk_div),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // apply quotient sign
    assign q_s = dv_side.neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});

    always_comb begin
        // no crossing: clamped start passes through
        if (!dv_side.hit) begin
            along = dv_side.base;
        // crossing sits at the clamped start: slide the end point onto the edge
        end else if (dv_side.startfix && dv_q == '0) begin
            along = dv_side.alt;
        end else begin
            along = dv_side.base + C_CW'(q_s);
        end
        n_x = dv_side.vert ? dv_side.fixed : along;
        n_y = dv_side.vert ? along : dv_side.fixed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x    <= n_x;
            r_out_y    <= n_y;
            r_out_hit  <= dv_side.hit;
            r_out_edge <= dv_side.edge_idx;
        end
    end

    assign o_clip.valid      = r_out_valid;
    assign o_clip.clip_x     = r_out_x;
    assign o_clip.clip_y     = r_out_y;
    assign o_clip.hit        = r_out_hit;
    assign o_clip.edge_index = r_out_edge;

endmodule

### tb/sv/srbc_checker.sv
`timescale 1ns / 1ps
module srbc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic               i_cfg_idx,
    input  logic [12:0]        i_cfg_data,
    srbc_in_if                 seg,
    srbc_out_if                clip,
    output int                 o_errors,
    output int                 o_pending
);
    import srbc_pkg::*;

    localparam int C_EXP_DEPTH = 256;

    typedef struct {
        logic [23:0] cx;
        logic [23:0] cy;
        logic        hit;
        logic [1:0]  edge_idx;
    } t_clip_exp;

    logic [12:0] width_px;
    logic [12:0] height_px;
    t_clip_exp   exp_buf[C_EXP_DEPTH];
    int          wr_ptr = 0;
    int          rd_ptr = 0;

    function automatic longint sext(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint lclamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint rdiv(longint n, longint d);
        bit neg;
        longint un;
        longint ud;
        longint q;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (2 * un + ud) / (2 * ud);
        return neg ? -q : q;
    endfunction

    function automatic t_clip_exp clip_segment(logic [23:0] sx, logic [23:0] sy,
                                               logic [23:0] ex_, logic [23:0] ey_);
        t_clip_exp r;
        longint wl, hl, x1, y1, x2, y2, dx, dy, bx, by, rx, ry;
        longint px[4], py[4];
        longint x3, y3, x4, y4, ex, ey, den, na, nb, hx, hy, mx, my, m;
        longint unsigned sqd, bestd;
        int best, j;
        wl = ((width_px == 0) ? 0 : width_px - 1) * 256;
        hl = ((height_px == 0) ? 0 : height_px - 1) * 256;
        px = '{0, wl, wl, 0};
        py = '{0, 0, hl, hl};
        x1 = lclamp(sext(sx), 0, wl);
        y1 = lclamp(sext(sy), 0, hl);
        x2 = sext(ex_);
        y2 = sext(ey_);
        dx = x2 - x1;
        dy = y2 - y1;
        best = -1;
        bestd = 0;
        bx = 0;
        by = 0;
        for (int i = 0; i < 4; i++) begin
            j = (i + 1) & 3;
            x3 = px[i]; y3 = py[i]; x4 = px[j]; y4 = py[j];
            ex = x4 - x3; ey = y4 - y3;
            den = ey * dx - ex * dy;
            na = ex * (y1 - y3) - ey * (x1 - x3);
            nb = dx * (y1 - y3) - dy * (x1 - x3);
            if (den == 0) continue;
            if (den < 0) begin
                den = -den; na = -na; nb = -nb;
            end
            if (na < 0 || na > den || nb < 0 || nb > den) continue;
            if (ey == 0) begin
                hy = y3;
                hx = x1 + rdiv((y3 - y1) * dx, dy);
            end else begin
                hx = x3;
                hy = y1 + rdiv((x3 - x1) * dy, dx);
            end
            mx = x3 + x4 - 2 * x2;
            my = y3 + y4 - 2 * y2;
            if (mx < 0) mx = -mx;
            if (my < 0) my = -my;
            sqd = longint'(mx * mx) + longint'(my * my);
            if (best < 0 || sqd < bestd) begin
                best = i; bestd = sqd; bx = hx; by = hy;
            end
        end
        if (best < 0) begin
            rx = x1; ry = y1;
        end else if (bx == x1 && by == y1) begin
            j = (best + 1) & 3;
            x3 = px[best]; y3 = py[best]; x4 = px[j]; y4 = py[j];
            // start sits on the edge: slide the far point along it
            if (x3 == x4) begin
                m = (y3 > y4) ? y3 : y4;
                rx = x3;
                ry = lclamp(y2, 0, m);
            end else begin
                m = (x3 > x4) ? x3 : x4;
                rx = lclamp(x2, 0, m);
                ry = y3;
            end
        end else begin
            rx = bx; ry = by;
        end
        r.cx = rx[23:0];
        r.cy = ry[23:0];
        r.hit = best >= 0;
        r.edge_idx = (best < 0) ? C_EDGE_TOP : best[1:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = wr_ptr - rd_ptr;

    always @(posedge i_clk) begin
        t_clip_exp e;
        if (!i_rst_n) begin
            width_px <= C_WIDTH_RST;
            height_px <= C_HEIGHT_RST;
        end else begin
            if (i_cfg_wen) begin
                if (i_cfg_idx == C_REG_WIDTH) width_px <= i_cfg_data;
                else height_px <= i_cfg_data;
            end
            if (seg.valid && seg.ready) begin
                exp_buf[wr_ptr % C_EXP_DEPTH] = clip_segment(seg.start_x, seg.start_y,
                                                             seg.end_x, seg.end_y);
                wr_ptr++;
            end
            if (clip.valid && clip.ready) begin
                if (wr_ptr == rd_ptr) begin
                    report("unexpected beat", 0, 0);
                end else begin
                    e = exp_buf[rd_ptr % C_EXP_DEPTH];
                    rd_ptr++;
                    if (clip.clip_x !== e.cx) report("clip_x", clip.clip_x, e.cx);
                    if (clip.clip_y !== e.cy) report("clip_y", clip.clip_y, e.cy);
                    if (clip.hit !== e.hit) report("hit", clip.hit, e.hit);
                    if (clip.edge_index !== e.edge_idx)
                        report("edge_index", clip.edge_index, e.edge_idx);
                end
            end
        end
    end
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import srbc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wen;
    logic        cfg_idx;
    logic [12:0] cfg_data;
    int          errors;
    int          pending;
    int          stall_mode;

    srbc_in_if  seg_ch();
    srbc_out_if clip_ch();

    segment_rect_boundary_clip DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_seg      (seg_ch.sink),
        .o_clip     (clip_ch.source)
    );

    srbc_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .seg        (seg_ch),
        .clip       (clip_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #3ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver back-pressure; pattern changes per phase
    always @(posedge i_clk) begin
        case (stall_mode)
            0: clip_ch.ready <= 1'b1;
            1: clip_ch.ready <= ($urandom_range(3) != 0);
            2: clip_ch.ready <= ($urandom_range(3) == 0);
            default: clip_ch.ready <= ~clip_ch.ready;
        endcase
    end

    task automatic write_reg(logic idx, logic [12:0] val);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    // one beat, held until accepted; a random gap may follow
    task automatic send_beat(logic [23:0] sx, logic [23:0] sy,
                             logic [23:0] ex, logic [23:0] ey, bit gap);
        seg_ch.valid <= 1'b1;
        seg_ch.start_x <= sx;
        seg_ch.start_y <= sy;
        seg_ch.end_x <= ex;
        seg_ch.end_y <= ey;
        do @(posedge i_clk); while (!seg_ch.ready);
        if (gap) begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [23:0] rand_crd(int wpx, int hpx, bit is_y);
        int span;
        span = (is_y ? hpx : wpx) * 256;
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(span + 512)) - 24'd256;
            2: return 24'(($urandom_range(is_y ? hpx : wpx)) * 256);
            default: return 24'($urandom_range(3 * span)) - 24'(span);
        endcase
    endfunction

    task automatic drain;
        seg_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        int wpx, hpx, burst, W, H;
        int sizes[6][2];
        logic [23:0] sx, sy;
        sizes = '{'{640, 480}, '{1, 1}, '{4096, 4096}, '{0, 7}, '{8191, 2}, '{3, 4096}};
        i_rst_n = 0;
        cfg_wen = 0;
        cfg_idx = 0;
        cfg_data = 0;
        stall_mode = 0;
        seg_ch.valid = 0;
        seg_ch.start_x = 0;
        seg_ch.start_y = 0;
        seg_ch.end_x = 0;
        seg_ch.end_y = 0;
        clip_ch.ready = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed beats at reset size 640 x 480
        W = 639 * 256;
        H = 479 * 256;
        send_beat(24'd1000, 24'd1000, -24'sd5000, 24'd1000, 0);   // left
        send_beat(24'd1000, 24'd1000, 24'd1000, -24'sd5000, 0);   // top
        send_beat(24'd1000, 24'd1000, 24'(W + 900), 24'd1000, 0); // right
        send_beat(24'd1000, 24'd1000, 24'd1000, 24'(H + 900), 0); // bottom
        send_beat(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 0); // extremes
        send_beat(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 1);
        send_beat(24'd0, 24'd0, -24'sd300, -24'sd300, 0);         // corner tie
        send_beat(24'd0, 24'd500, 24'd0, -24'sd800, 0);           // start on edge
        send_beat(24'd0, 24'd500, -24'sd900, 24'd900, 0);
        send_beat(24'd300, 24'd0, 24'd900, -24'sd900, 0);
        send_beat(24'd500, 24'd500, 24'd600, 24'd600, 0);         // no crossing
        send_beat(24'd500, 24'd500, 24'd500, 24'd500, 0);         // zero length
        send_beat(24'd100, 24'd100, -24'sd3, 24'd700, 0);         // rounding
        send_beat(24'd100, 24'd100, -24'sd7, -24'sd1, 1);
        drain();

        // phases over sizes, including the extremes and zero
        foreach (sizes[p]) begin
            wpx = sizes[p][0];
            hpx = sizes[p][1];
            write_reg(C_REG_WIDTH, 13'(wpx));
            write_reg(C_REG_HEIGHT, 13'(hpx));
            stall_mode = p % 4;
            if (wpx == 0) wpx = 1;
            for (int n = 0; n < 275; n += burst) begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst; k++) begin
                    sx = rand_crd(wpx, hpx, 0);
                    sy = rand_crd(wpx, hpx, 1);
                    send_beat(sx, sy, rand_crd(wpx, hpx, 0), rand_crd(wpx, hpx, 1), 0);
                end
                if ($urandom_range(2) != 0) begin
                    seg_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
